### rtl/core/bem_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and element compare functions for the broadcast max block.
package bem_pkg;

   localparam int RANK       = 7;
   localparam int X_DEPTH    = 1024;
   localparam int Y_DEPTH    = 1024;
   localparam int ELEM_WIDTH = 64;

   localparam int MAX_DEPTH = (X_DEPTH > Y_DEPTH) ? X_DEPTH : Y_DEPTH;
   localparam int IDX_W     = $clog2(MAX_DEPTH + 1);
   localparam int PROD_W    = IDX_W + 8;
   localparam int SUM_W     = IDX_W + 9;
   localparam int X_AW      = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;
   localparam int Y_AW      = (Y_DEPTH > 1) ? $clog2(Y_DEPTH) : 1;
   localparam int DIM_W     = (RANK > 1) ? $clog2(RANK) : 1;

   localparam int REQ_TYPE_W = 2;
   localparam int INDEX_W    = 10;
   localparam int VALUE_W    = 64;
   localparam int STATUS_W   = 2;
   localparam int SHAPE_W    = 56;
   localparam int KIND_W     = 3;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int EXT_INDEX_W = 17;

   localparam logic [SHAPE_W-1:0] SHAPE_RESET = 56'h01_0101_0101_0101;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_WRITE_X = 2'd0,
      REQ_WRITE_Y = 2'd1,
      REQ_EMIT    = 2'd2
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_DIM = 2'd1,
      STATUS_RANGE    = 2'd2
   } status_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_BOOL   = 3'd0,
      KIND_INT8   = 3'd1,
      KIND_UINT8  = 3'd2,
      KIND_INT16  = 3'd3,
      KIND_INT32  = 3'd4,
      KIND_INT64  = 3'd5,
      KIND_UINT32 = 3'd6,
      KIND_UINT64 = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      REG_X_SHAPE   = 2'd0,
      REG_Y_SHAPE   = 2'd1,
      REG_OUT_SHAPE = 2'd2,
      REG_ELEM_KIND = 2'd3
   } reg_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INDEX,
      ST_READ,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [SHAPE_W-1:0] x_shape;
      logic [SHAPE_W-1:0] y_shape;
      logic [SHAPE_W-1:0] out_shape;
      kind_type           elem_kind;
   } cfg_type;

   // Flat index accumulator; big means the scaled stride reached the store depth.
   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] stride;
      logic             big;
      logic             ovf;
   } acc_type;

   function automatic logic [VALUE_W-1:0] kind_mask(kind_type kind);
      logic [VALUE_W-1:0] mask;
      case (kind) inside
         KIND_BOOL, KIND_INT8, KIND_UINT8: mask = 64'h0000_0000_0000_00FF;
         KIND_INT16:                       mask = 64'h0000_0000_0000_FFFF;
         KIND_INT32, KIND_UINT32:          mask = 64'h0000_0000_FFFF_FFFF;
         default:                          mask = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return mask;
   endfunction

   function automatic logic [VALUE_W-1:0] kind_sign(kind_type kind);
      logic [VALUE_W-1:0] sign;
      case (kind)
         KIND_INT8:  sign = 64'h0000_0000_0000_0080;
         KIND_INT16: sign = 64'h0000_0000_0000_8000;
         KIND_INT32: sign = 64'h0000_0000_8000_0000;
         KIND_INT64: sign = 64'h8000_0000_0000_0000;
         default:    sign = 64'h0;
      endcase
      return sign;
   endfunction

   function automatic logic [VALUE_W-1:0] larger(kind_type kind, logic [VALUE_W-1:0] a,
                                                 logic [VALUE_W-1:0] b);
      logic [VALUE_W-1:0] am;
      logic [VALUE_W-1:0] bm;
      logic [VALUE_W-1:0] sign;
      logic [VALUE_W-1:0] result;
      am   = a & kind_mask(kind);
      bm   = b & kind_mask(kind);
      sign = kind_sign(kind);
      if (kind == KIND_BOOL) begin
         result = ((a[7:0] != 8'd0) || (b[7:0] != 8'd0)) ? 64'd1 : 64'd0;
      end else begin
         result = ((am ^ sign) >= (bm ^ sign)) ? am : bm;
      end
      return result;
   endfunction

endpackage

### rtl/core/bem_req_if.sv
`timescale 1ns / 1ps
// Request channel interface: valid/ready handshake with the request payload.
interface bem_req_if;
   logic                            valid;
   logic                            ready;
   logic [bem_pkg::REQ_TYPE_W-1:0]  req_type;
   logic [bem_pkg::INDEX_W-1:0]     entry_index;
   logic [bem_pkg::VALUE_W-1:0]     entry_value;

   modport source (output valid, output req_type, output entry_index, output entry_value,
                   input ready);
   modport sink (input valid, input req_type, input entry_index, input entry_value,
                 output ready);
endinterface

### rtl/core/bem_rsp_if.sv
`timescale 1ns / 1ps
// Response channel interface: valid/ready handshake with the result payload.
interface bem_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bem_pkg::VALUE_W-1:0]   max_value;
   logic                          last_of_run;
   logic [bem_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output max_value, output last_of_run, output status,
                   input ready);
   modport sink (input valid, input max_value, input last_of_run, input status,
                 output ready);
endinterface

### rtl/core/bem_ram.sv
`timescale 1ns / 1ps
// Single-port element store with registered read data.
module bem_ram #(
   parameter int DEPTH  = 1024,
   parameter int WIDTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wr_data,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/bem_idx_unit.sv
`timescale 1ns / 1ps
// Shared flat index step: adds one dimension's term and scales the stride, saturating at depth.
module bem_idx_unit (
   input  bem_pkg::acc_type           acc_in,
   input  logic [7:0]                 dim_size,
   input  logic [7:0]                 coord,
   input  logic [bem_pkg::IDX_W-1:0]  limit,
   output bem_pkg::acc_type           acc_out
);

   logic [7:0]                  used_coord;
   logic [bem_pkg::PROD_W-1:0]  term;
   logic [bem_pkg::PROD_W-1:0]  stride_prod;
   logic [bem_pkg::SUM_W-1:0]   sum;

   always_comb begin
      used_coord  = (dim_size == 8'd1) ? 8'd0 : coord;
      term        = (bem_pkg::PROD_W)'(used_coord) * (bem_pkg::PROD_W)'(acc_in.stride);
      sum         = (bem_pkg::SUM_W)'(acc_in.idx) + (bem_pkg::SUM_W)'(term);
      stride_prod = (bem_pkg::PROD_W)'(dim_size) * (bem_pkg::PROD_W)'(acc_in.stride);

      acc_out.idx = sum[bem_pkg::IDX_W-1:0];
      acc_out.ovf = acc_in.ovf || (acc_in.big && (used_coord != 8'd0)) ||
                    (sum >= (bem_pkg::SUM_W)'(limit));

      if (dim_size == 8'd0) begin
         acc_out.stride = '0;
         acc_out.big    = 1'b0;
      end else if (acc_in.big) begin
         acc_out.stride = acc_in.stride;
         acc_out.big    = 1'b1;
      end else if (stride_prod >= (bem_pkg::PROD_W)'(limit)) begin
         acc_out.stride = acc_in.stride;
         acc_out.big    = 1'b1;
      end else begin
         acc_out.stride = stride_prod[bem_pkg::IDX_W-1:0];
         acc_out.big    = 1'b0;
      end
   end

endmodule

### rtl/core/bem_csr.sv
`timescale 1ns / 1ps
// APB-style configuration registers: shapes and element kind.
module bem_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bem_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bem_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bem_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready,
   output bem_pkg::cfg_type                   cfg,
   output logic                               coord_clear
);

   logic [bem_pkg::SHAPE_W-1:0] x_shape_ff, x_shape_in;
   logic [bem_pkg::SHAPE_W-1:0] y_shape_ff, y_shape_in;
   logic [bem_pkg::SHAPE_W-1:0] out_shape_ff, out_shape_in;
   bem_pkg::kind_type           elem_kind_ff, elem_kind_in;
   bem_pkg::reg_code_type       reg_sel;
   logic                        wr_strobe;

   assign reg_sel    = bem_pkg::reg_code_type'(csr_paddr[4:3]);
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      x_shape_in   = x_shape_ff;
      y_shape_in   = y_shape_ff;
      out_shape_in = out_shape_ff;
      elem_kind_in = elem_kind_ff;
      coord_clear  = 1'b0;
      if (wr_strobe) begin
         unique case (reg_sel)
            bem_pkg::REG_X_SHAPE: begin
               x_shape_in  = csr_pwdata[bem_pkg::SHAPE_W-1:0];
               coord_clear = 1'b1;
            end
            bem_pkg::REG_Y_SHAPE: begin
               y_shape_in  = csr_pwdata[bem_pkg::SHAPE_W-1:0];
               coord_clear = 1'b1;
            end
            bem_pkg::REG_OUT_SHAPE: begin
               out_shape_in = csr_pwdata[bem_pkg::SHAPE_W-1:0];
               coord_clear  = 1'b1;
            end
            bem_pkg::REG_ELEM_KIND: begin
               elem_kind_in = bem_pkg::kind_type'(csr_pwdata[bem_pkg::KIND_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_shape_ff   <= bem_pkg::SHAPE_RESET;
         y_shape_ff   <= bem_pkg::SHAPE_RESET;
         out_shape_ff <= bem_pkg::SHAPE_RESET;
         elem_kind_ff <= bem_pkg::KIND_BOOL;
      end else begin
         x_shape_ff   <= x_shape_in;
         y_shape_ff   <= y_shape_in;
         out_shape_ff <= out_shape_in;
         elem_kind_ff <= elem_kind_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         bem_pkg::REG_X_SHAPE:   csr_prdata = (bem_pkg::CSR_DATA_W)'(x_shape_ff);
         bem_pkg::REG_Y_SHAPE:   csr_prdata = (bem_pkg::CSR_DATA_W)'(y_shape_ff);
         bem_pkg::REG_OUT_SHAPE: csr_prdata = (bem_pkg::CSR_DATA_W)'(out_shape_ff);
         bem_pkg::REG_ELEM_KIND: csr_prdata = (bem_pkg::CSR_DATA_W)'(elem_kind_ff);
         default:                csr_prdata = '0;
      endcase
   end

   assign cfg.x_shape   = x_shape_ff;
   assign cfg.y_shape   = y_shape_ff;
   assign cfg.out_shape = out_shape_ff;
   assign cfg.elem_kind = elem_kind_ff;

endmodule

### rtl/core/bem_seq.sv
`timescale 1ns / 1ps
// Request sequencer: element stores, coordinate counter, index loop and response register.
module bem_seq (
   input  logic              clock,
   input  logic              reset,
   bem_req_if.sink           req_if,
   bem_rsp_if.source         rsp_if,
   input  bem_pkg::cfg_type  cfg,
   input  logic              coord_clear
);

   bem_pkg::state_type state_ff, state_in;

   logic [bem_pkg::DIM_W-1:0] dim_ff, dim_in;
   logic                      side_ff, side_in;
   logic                      zero_ff, zero_in;
   bem_pkg::acc_type          x_acc_ff, x_acc_in;
   bem_pkg::acc_type          y_acc_ff, y_acc_in;
   bem_pkg::acc_type          x_init, y_init, step_in, step_out;
   logic [7:0]                coord_ff [bem_pkg::RANK];
   logic [7:0]                coord_in [bem_pkg::RANK];
   logic [bem_pkg::RANK:0]    carry;
   logic [bem_pkg::RANK-1:0]  wrap;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bem_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                        rsp_last_ff, rsp_last_in;
   bem_pkg::status_type         rsp_status_ff, rsp_status_in;

   logic                           accept, is_emit, wr_x, wr_y, zero_dim;
   logic                           rsp_free, load_rsp, rd_en, step_en, req_ready;
   logic [bem_pkg::EXT_INDEX_W-1:0] ei_ext;
   logic [bem_pkg::SHAPE_W-1:0]    step_shape;
   logic [7:0]                     step_size, step_coord;
   logic [bem_pkg::IDX_W-1:0]      step_limit;
   logic [bem_pkg::X_AW-1:0]       x_addr;
   logic [bem_pkg::Y_AW-1:0]       y_addr;
   logic [bem_pkg::ELEM_WIDTH-1:0] x_rdata, y_rdata;

   assign accept   = req_if.valid && req_ready;
   assign is_emit  = (req_if.req_type == bem_pkg::REQ_EMIT);
   assign ei_ext   = (bem_pkg::EXT_INDEX_W)'(req_if.entry_index);
   assign wr_x     = accept && (req_if.req_type == bem_pkg::REQ_WRITE_X) &&
                     (ei_ext < (bem_pkg::EXT_INDEX_W)'(bem_pkg::X_DEPTH));
   assign wr_y     = accept && (req_if.req_type == bem_pkg::REQ_WRITE_Y) &&
                     (ei_ext < (bem_pkg::EXT_INDEX_W)'(bem_pkg::Y_DEPTH));
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = req_ready;

   always_comb begin
      zero_dim = 1'b0;
      for (int d = 0; d < bem_pkg::RANK; d++) begin
         zero_dim = zero_dim || (cfg.out_shape[8*d +: 8] == 8'd0);
      end
   end

   // FSM next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bem_pkg::ST_IDLE: begin
            if (accept && is_emit) begin
               state_in = zero_dim ? bem_pkg::ST_RESULT : bem_pkg::ST_INDEX;
            end
         end
         bem_pkg::ST_INDEX: begin
            if (side_ff && (dim_ff == (bem_pkg::DIM_W)'(bem_pkg::RANK - 1))) begin
               state_in = bem_pkg::ST_READ;
            end
         end
         bem_pkg::ST_READ: begin
            state_in = bem_pkg::ST_RESULT;
         end
         bem_pkg::ST_RESULT: begin
            if (rsp_free) begin
               state_in = bem_pkg::ST_IDLE;
            end
         end
         default: state_in = bem_pkg::ST_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      req_ready = 1'b0;
      step_en   = 1'b0;
      rd_en     = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         bem_pkg::ST_IDLE:   req_ready = 1'b1;
         bem_pkg::ST_INDEX:  step_en   = 1'b1;
         bem_pkg::ST_READ:   rd_en     = 1'b1;
         bem_pkg::ST_RESULT: load_rsp  = rsp_free;
         default: begin
         end
      endcase
   end

   // index loop: x then y for each dimension, innermost first
   always_comb begin
      x_init.idx    = '0;
      x_init.stride = (bem_pkg::IDX_W)'(1);
      x_init.big    = (bem_pkg::X_DEPTH <= 1);
      x_init.ovf    = 1'b0;
      y_init.idx    = '0;
      y_init.stride = (bem_pkg::IDX_W)'(1);
      y_init.big    = (bem_pkg::Y_DEPTH <= 1);
      y_init.ovf    = 1'b0;

      step_in    = side_ff ? y_acc_ff : x_acc_ff;
      step_shape = side_ff ? cfg.y_shape : cfg.x_shape;
      step_size  = step_shape[{dim_ff, 3'b000} +: 8];
      step_coord = coord_ff[dim_ff];
      step_limit = side_ff ? (bem_pkg::IDX_W)'(bem_pkg::Y_DEPTH)
                           : (bem_pkg::IDX_W)'(bem_pkg::X_DEPTH);

      dim_in   = dim_ff;
      side_in  = side_ff;
      zero_in  = zero_ff;
      x_acc_in = x_acc_ff;
      y_acc_in = y_acc_ff;
      if (accept && is_emit) begin
         dim_in   = '0;
         side_in  = 1'b0;
         zero_in  = zero_dim;
         x_acc_in = x_init;
         y_acc_in = y_init;
      end else if (step_en) begin
         side_in = !side_ff;
         if (side_ff) begin
            dim_in   = dim_ff + (bem_pkg::DIM_W)'(1);
            y_acc_in = step_out;
         end else begin
            x_acc_in = step_out;
         end
      end
   end

   bem_idx_unit u_idx_unit (
      .acc_in   (step_in),
      .dim_size (step_size),
      .coord    (step_coord),
      .limit    (step_limit),
      .acc_out  (step_out)
   );

   assign x_addr = (state_ff == bem_pkg::ST_IDLE) ? ei_ext[bem_pkg::X_AW-1:0]
                                                  : x_acc_ff.idx[bem_pkg::X_AW-1:0];
   assign y_addr = (state_ff == bem_pkg::ST_IDLE) ? ei_ext[bem_pkg::Y_AW-1:0]
                                                  : y_acc_ff.idx[bem_pkg::Y_AW-1:0];

   bem_ram #(
      .DEPTH (bem_pkg::X_DEPTH),
      .WIDTH (bem_pkg::ELEM_WIDTH)
   ) u_x_store (
      .clock   (clock),
      .wr_en   (wr_x),
      .rd_en   (rd_en),
      .addr    (x_addr),
      .wr_data (req_if.entry_value[bem_pkg::ELEM_WIDTH-1:0]),
      .rd_data (x_rdata)
   );

   bem_ram #(
      .DEPTH (bem_pkg::Y_DEPTH),
      .WIDTH (bem_pkg::ELEM_WIDTH)
   ) u_y_store (
      .clock   (clock),
      .wr_en   (wr_y),
      .rd_en   (rd_en),
      .addr    (y_addr),
      .wr_data (req_if.entry_value[bem_pkg::ELEM_WIDTH-1:0]),
      .rd_data (y_rdata)
   );

   // odometer advance, innermost dimension first
   always_comb begin
      carry[0] = 1'b1;
      for (int d = 0; d < bem_pkg::RANK; d++) begin
         wrap[d] = ({1'b0, coord_ff[d]} + 9'd1) >= {1'b0, cfg.out_shape[8*d +: 8]};
         if (carry[d]) begin
            coord_in[d] = wrap[d] ? 8'd0 : (coord_ff[d] + 8'd1);
         end else begin
            coord_in[d] = coord_ff[d];
         end
         carry[d+1] = carry[d] && wrap[d];
      end
   end

   always_comb begin
      rsp_value_in  = '0;
      rsp_last_in   = 1'b1;
      rsp_status_in = bem_pkg::STATUS_ZERO_DIM;
      if (!zero_ff) begin
         rsp_last_in = carry[bem_pkg::RANK];
         if (x_acc_ff.ovf || y_acc_ff.ovf) begin
            rsp_status_in = bem_pkg::STATUS_RANGE;
         end else begin
            rsp_status_in = bem_pkg::STATUS_OK;
            rsp_value_in  = bem_pkg::larger(cfg.elem_kind, (bem_pkg::VALUE_W)'(x_rdata),
                                            (bem_pkg::VALUE_W)'(y_rdata));
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bem_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int d = 0; d < bem_pkg::RANK; d++) begin
         if (reset || coord_clear) begin
            coord_ff[d] <= 8'd0;
         end else if (load_rsp && !zero_ff) begin
            coord_ff[d] <= coord_in[d];
         end
      end
   end

   always_ff @(posedge clock) begin
      dim_ff   <= dim_in;
      side_ff  <= side_in;
      zero_ff  <= zero_in;
      x_acc_ff <= x_acc_in;
      y_acc_ff <= y_acc_in;
      if (load_rsp) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.max_value   = rsp_value_ff;
   assign rsp_if.last_of_run = rsp_last_ff;
   assign rsp_if.status      = rsp_status_ff;

endmodule

### rtl/core/broadcast_elementwise_max.sv
`timescale 1ns / 1ps
// Broadcast elementwise maximum of two stored integer tensors of up to seven dimensions.
//
// Channels: requests on req_if (valid/ready), results on rsp_if (valid/ready),
// configuration through the APB-style csr_ port (shapes and element kind, 64-bit
// registers at byte addresses 0, 8, 16, 24; pready always high).
// A write request (x or y store) is taken while the sequencer is idle and gives no result.
// An emit request walks the flat index of x and y through one shared index
// step unit, one dimension of one side per cycle, then reads both stores and
// compares. The result is registered in the result state, after the read state,
// and the next request is taken once the sequencer is back in idle.
// An emit with a zero output dimension skips the index and read states and goes
// straight to the result state.
// Requests are taken one at a time; ready is low while an emit is in progress.
// A finished result waits in the output register while the next request is
// accepted; if the receiver stalls, the following emit holds in its last step.
// Reset clears the sequencer, the output valid, the coordinate counter and the
// registers (shapes all size one, element kind bool). Store contents are
// undefined until written; writing a shape register restarts the coordinates.
module broadcast_elementwise_max (
   input  logic                            clock,
   input  logic                            reset,
   bem_req_if.sink                         req_if,
   bem_rsp_if.source                       rsp_if,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bem_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bem_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bem_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   bem_pkg::cfg_type cfg;
   logic             coord_clear;

   bem_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .coord_clear (coord_clear)
   );

   bem_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .cfg         (cfg),
      .coord_clear (coord_clear)
   );

   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && (req_if.req_type != bem_pkg::REQ_EMIT) &&
       !rsp_if.valid) |=> !rsp_if.valid)
      else $error("write request produced a result");

   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && (req_if.req_type == bem_pkg::REQ_EMIT))
      |=> !req_if.ready)
      else $error("ready stayed high after an emit request");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(!req_if.ready))
      else $error("result appeared without the sequencer being busy");

endmodule

### test/tb_broadcast_elementwise_max.sv
`timescale 1ns / 1ps
// Self-checking testbench for broadcast_elementwise_max: directed and random requests.
module tb_broadcast_elementwise_max;
   import bem_pkg::*;

   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 40;

   typedef enum {SHAPE_ALL_MAX, SHAPE_ALL_ZERO, SHAPE_NOISE, SHAPE_ONE_WIDE,
                 SHAPE_BROADCAST} shape_style_type;

   typedef struct packed {
      logic [VALUE_W-1:0] max_value;
      logic               last_of_run;
      status_type         status;
   } max_result_type;

   class max_scoreboard;
      logic [SHAPE_W-1:0] x_shape;
      logic [SHAPE_W-1:0] y_shape;
      logic [SHAPE_W-1:0] out_shape;
      kind_type           kind;
      logic [VALUE_W-1:0] x_mem [X_DEPTH];
      logic [VALUE_W-1:0] y_mem [Y_DEPTH];
      bit                 x_written [X_DEPTH];
      bit                 y_written [Y_DEPTH];
      logic [7:0]         coord [RANK];
      max_result_type     awaited_max [$];
      int errors, n_ok, n_zero, n_range, n_last, n_writes;

      function new();
         x_shape   = SHAPE_RESET;
         y_shape   = SHAPE_RESET;
         out_shape = SHAPE_RESET;
         kind      = KIND_BOOL;
         foreach (coord[d]) coord[d] = 8'd0;
         foreach (x_written[i]) x_written[i] = 1'b0;
         foreach (y_written[i]) y_written[i] = 1'b0;
         errors = 0; n_ok = 0; n_zero = 0; n_range = 0; n_last = 0; n_writes = 0;
      endfunction

      function void clear_coords();
         foreach (coord[d]) coord[d] = 8'd0;
      endfunction

      function void configure(reg_code_type r, logic [CSR_DATA_W-1:0] v);
         case (r)
            REG_X_SHAPE:   begin x_shape = v[SHAPE_W-1:0]; clear_coords(); end
            REG_Y_SHAPE:   begin y_shape = v[SHAPE_W-1:0]; clear_coords(); end
            REG_OUT_SHAPE: begin out_shape = v[SHAPE_W-1:0]; clear_coords(); end
            REG_ELEM_KIND: kind = kind_type'(v[KIND_W-1:0]);
         endcase
      endfunction

      function bit zero_dim();
         int d;
         for (d = 0; d < RANK; d++)
            if (out_shape[8*d +: 8] == 8'd0) return 1'b1;
         return 1'b0;
      endfunction

      // Row-major index on one side's own shape; size-1 dimensions broadcast.
      function longint unsigned flat_index(logic [SHAPE_W-1:0] shape);
         longint unsigned idx;
         longint unsigned stride;
         logic [7:0]      sz;
         int              d;
         idx = 0;
         stride = 1;
         for (d = 0; d < RANK; d++) begin
            sz = shape[8*d +: 8];
            if (sz != 8'd1) idx += coord[d] * stride;
            stride *= sz;
         end
         return idx;
      endfunction

      function int missing_x();
         longint unsigned xi;
         if (zero_dim()) return -1;
         xi = flat_index(x_shape);
         return (xi < X_DEPTH && !x_written[xi]) ? int'(xi) : -1;
      endfunction

      function int missing_y();
         longint unsigned yi;
         if (zero_dim()) return -1;
         yi = flat_index(y_shape);
         return (yi < Y_DEPTH && !y_written[yi]) ? int'(yi) : -1;
      endfunction

      function logic [VALUE_W-1:0] pick_max(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b);
         logic [VALUE_W-1:0] res;
         case (kind)
            KIND_BOOL:   res = (a[7:0] != 8'd0 || b[7:0] != 8'd0) ? 64'd1 : 64'd0;
            KIND_INT8:   res = ($signed(a[7:0]) >= $signed(b[7:0])) ?
                               {56'd0, a[7:0]} : {56'd0, b[7:0]};
            KIND_UINT8:  res = (a[7:0] >= b[7:0]) ? {56'd0, a[7:0]} : {56'd0, b[7:0]};
            KIND_INT16:  res = ($signed(a[15:0]) >= $signed(b[15:0])) ?
                               {48'd0, a[15:0]} : {48'd0, b[15:0]};
            KIND_INT32:  res = ($signed(a[31:0]) >= $signed(b[31:0])) ?
                               {32'd0, a[31:0]} : {32'd0, b[31:0]};
            KIND_INT64:  res = ($signed(a) >= $signed(b)) ? a : b;
            KIND_UINT32: res = (a[31:0] >= b[31:0]) ? {32'd0, a[31:0]} : {32'd0, b[31:0]};
            default:     res = (a >= b) ? a : b;
         endcase
         return res;
      endfunction

      function max_result_type next_max_result();
         max_result_type  r;
         longint unsigned xi;
         longint unsigned yi;
         bit              carry;
         int              d;
         if (zero_dim()) begin
            r.max_value = '0;
            r.last_of_run = 1'b1;
            r.status = STATUS_ZERO_DIM;
            n_zero++;
            return r;
         end
         xi = flat_index(x_shape);
         yi = flat_index(y_shape);
         if (xi >= X_DEPTH || yi >= Y_DEPTH) begin
            r.max_value = '0;
            r.status = STATUS_RANGE;
            n_range++;
         end else begin
            r.max_value = pick_max(x_mem[xi], y_mem[yi]);
            r.status = STATUS_OK;
            n_ok++;
         end
         carry = 1'b1;
         for (d = 0; d < RANK && carry; d++) begin
            if ({1'b0, coord[d]} + 9'd1 >= {1'b0, out_shape[8*d +: 8]}) begin
               coord[d] = 8'd0;
            end else begin
               coord[d] = coord[d] + 8'd1;
               carry = 1'b0;
            end
         end
         r.last_of_run = carry;
         if (carry) n_last++;
         return r;
      endfunction

      function void note_request(logic [REQ_TYPE_W-1:0] rtype, logic [INDEX_W-1:0] idx,
                                 logic [VALUE_W-1:0] val);
         case (rtype)
            REQ_WRITE_X: begin x_mem[idx] = val; x_written[idx] = 1'b1; n_writes++; end
            REQ_WRITE_Y: begin y_mem[idx] = val; y_written[idx] = 1'b1; n_writes++; end
            REQ_EMIT:    awaited_max.push_back(next_max_result());
            default:     ;
         endcase
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= 100) $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      task check_result(logic [VALUE_W-1:0] v, logic last, logic [STATUS_W-1:0] st);
         max_result_type e;
         if (awaited_max.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %h last %0b status %0d",
                                      v, last, st));
            return;
         end
         e = awaited_max.pop_front();
         if (v !== e.max_value)
            report_mismatch($sformatf("max_value %h, want %h", v, e.max_value));
         if (last !== e.last_of_run)
            report_mismatch($sformatf("last_of_run %b, want %b", last, e.last_of_run));
         if (st !== e.status)
            report_mismatch($sformatf("status %0d, want %0d", st, e.status));
      endtask

      task report_leftover();
         if (awaited_max.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_max.size()));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  rsp_ready = 1'b0;
   bit                    calm = 1'b0;
   int                    sent_items = 0;
   int                    phase = 0;

   max_scoreboard sb = new();

   bem_req_if req_ch ();
   bem_rsp_if rsp_ch ();

   assign rsp_ch.ready = rsp_ready;

   broadcast_elementwise_max dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("timeout with %0d results outstanding", sb.awaited_max.size());
      $display("FAILURE");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= reset ? 1'b0 : (calm || $urandom_range(0, 99) >= 8);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result(rsp_ch.max_value, rsp_ch.last_of_run, rsp_ch.status);
   end

   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] v;
      case ($urandom_range(0, 7))
         0:       v = '0;
         1:       v = '1;
         2:       v = 64'd1 << $urandom_range(0, 63);
         3:       v = ~(64'd1 << $urandom_range(0, 63));
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   function automatic logic [INDEX_W-1:0] pick_index();
      return $urandom_range(0, 1) ? INDEX_W'($urandom_range(0, 1023))
                                  : INDEX_W'($urandom_range(0, 63));
   endfunction

   task automatic send_request(logic [REQ_TYPE_W-1:0] rtype, logic [INDEX_W-1:0] idx,
                               logic [VALUE_W-1:0] val);
      while (!calm && $urandom_range(0, 99) < 8) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= rtype;
      req_ch.entry_index <= idx;
      req_ch.entry_value <= val;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(rtype, idx, val);
      sent_items++;
   endtask

   // Fill any store entry the next emit reads before issuing it.
   task automatic send_emit();
      int gx;
      int gy;
      gx = sb.missing_x();
      if (gx >= 0) send_request(REQ_WRITE_X, gx[INDEX_W-1:0], random_value());
      gy = sb.missing_y();
      if (gy >= 0) send_request(REQ_WRITE_Y, gy[INDEX_W-1:0], random_value());
      send_request(REQ_EMIT, INDEX_W'($urandom), random_value());
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.awaited_max.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(reg_code_type r, logic [CSR_DATA_W-1:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 3'b000};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.configure(r, v);
      @(posedge clock);
   endtask

   task automatic set_config(logic [SHAPE_W-1:0] xs, logic [SHAPE_W-1:0] ys,
                             logic [SHAPE_W-1:0] os, kind_type kind);
      logic [CSR_DATA_W-1:0] kv;
      drain();
      csr_write(REG_X_SHAPE, {8'($urandom), xs});
      csr_write(REG_Y_SHAPE, {8'($urandom), ys});
      csr_write(REG_OUT_SHAPE, {8'($urandom), os});
      kv = {$urandom, $urandom};
      kv[KIND_W-1:0] = kind;
      csr_write(REG_ELEM_KIND, kv);
   endtask

   // Mostly broadcast-compatible shapes with few output positions.
   task automatic pick_shapes(int ph, output logic [SHAPE_W-1:0] xs,
                              output logic [SHAPE_W-1:0] ys, output logic [SHAPE_W-1:0] os);
      shape_style_type style;
      int              sel;
      int              rank;
      int              total;
      int              d;
      logic [7:0]      od;
      if (ph == 0) style = SHAPE_ALL_MAX;
      else if (ph == 1) style = SHAPE_ALL_ZERO;
      else begin
         sel = $urandom_range(0, 19);
         style = (sel == 0) ? SHAPE_NOISE : (sel == 1) ? SHAPE_ONE_WIDE : SHAPE_BROADCAST;
      end
      xs = SHAPE_RESET;
      ys = SHAPE_RESET;
      os = SHAPE_RESET;
      case (style)
         SHAPE_ALL_MAX:  begin xs = '1; ys = '1; os = '1; end
         SHAPE_ALL_ZERO: begin xs = '0; ys = '0; os = '0; end
         SHAPE_NOISE: begin
            xs = SHAPE_W'({$urandom, $urandom});
            ys = SHAPE_W'({$urandom, $urandom});
            os = SHAPE_W'({$urandom, $urandom});
         end
         SHAPE_ONE_WIDE: begin
            d = $urandom_range(0, RANK - 1);
            od = 8'($urandom_range(100, 255));
            os[8*d +: 8] = od;
            xs[8*d +: 8] = $urandom_range(0, 1) ? od : 8'd1;
            ys[8*d +: 8] = od;
         end
         default: begin
            rank = $urandom_range(1, RANK);
            total = 1;
            for (d = 0; d < rank; d++) begin
               od = 8'($urandom_range(1, 5));
               if (total * od > 64) od = 8'd1;
               total = total * od;
               xs[8*d +: 8] = ($urandom_range(0, 2) == 0) ? 8'd1 : od;
               ys[8*d +: 8] = ($urandom_range(0, 2) == 0) ? 8'd1 : od;
               if ($urandom_range(0, 29) == 0) xs[8*d +: 8] = 8'($urandom_range(0, 255));
               if ($urandom_range(0, 29) == 0) ys[8*d +: 8] = 8'($urandom_range(0, 255));
               if ($urandom_range(0, 39) == 0) od = 8'd0;
               os[8*d +: 8] = od;
            end
         end
      endcase
   endtask

   initial begin
      logic [SHAPE_W-1:0] xs;
      logic [SHAPE_W-1:0] ys;
      logic [SHAPE_W-1:0] os;
      kind_type           kind;
      int                 n;
      int                 sel;

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.req_type    <= REQ_WRITE_X;
      req_ch.entry_index <= '0;
      req_ch.entry_value <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // scalar bool after reset
      send_request(REQ_WRITE_X, 10'd0, 64'd0);
      send_request(REQ_WRITE_Y, 10'd0, 64'd0);
      send_emit();
      send_request(REQ_WRITE_X, 10'd0, 64'h100);
      send_emit();
      send_request(REQ_WRITE_Y, 10'd0, 64'hFF);
      send_emit();
      send_request(REQ_UNUSED, 10'h3FF, '1);
      send_request(REQ_WRITE_X, 10'h3FF, '1);

      // signed compare, y broadcast along the inner dimension
      set_config(56'h01_0101_0101_0102, SHAPE_RESET, 56'h01_0101_0101_0102, KIND_INT8);
      send_request(REQ_WRITE_X, 10'd0, 64'h80);
      send_request(REQ_WRITE_X, 10'd1, 64'h7F);
      send_request(REQ_WRITE_Y, 10'd0, 64'hFF);
      send_emit();
      send_emit();
      set_config(56'h01_0101_0101_0102, SHAPE_RESET, 56'h01_0101_0101_0102, KIND_INT64);
      send_request(REQ_WRITE_X, 10'd0, 64'h8000_0000_0000_0000);
      send_request(REQ_WRITE_Y, 10'd0, 64'd0);
      send_emit();
      send_emit();

      // zero output dimension
      set_config(SHAPE_RESET, SHAPE_RESET, 56'h01_0101_0101_0100, KIND_UINT32);
      send_emit();

      // x index runs past the store on the second position
      set_config(56'h01_0101_0102_FFFF, SHAPE_RESET, 56'h01_0101_0102_0101, KIND_UINT8);
      send_emit();
      send_emit();

      while (sent_items < 1820) begin
         calm = (phase >= 8 && phase < 14);
         pick_shapes(phase, xs, ys, os);
         if (phase == 0) kind = KIND_UINT64;
         else if (phase == 1) kind = KIND_BOOL;
         else kind = kind_type'($urandom_range(0, 7));
         set_config(xs, ys, os, kind);
         n = $urandom_range(20, 60);
         repeat (n) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) send_emit();
            else if (sel < 75) send_request(REQ_WRITE_X, pick_index(), random_value());
            else if (sel < 95) send_request(REQ_WRITE_Y, pick_index(), random_value());
            else send_request(REQ_UNUSED, INDEX_W'($urandom), {$urandom, $urandom});
         end
         phase++;
      end
      calm = 1'b0;

      drain();
      sb.report_leftover();
      $display("covered %0d requests over %0d random shape phases, %0d store writes",
               sent_items, phase, sb.n_writes);
      $display("results: %0d ok, %0d zero-dim, %0d out-of-range, %0d completed runs",
               sb.n_ok, sb.n_zero, sb.n_range, sb.n_last);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
